FILE: rtl/six_bit_text_stream_codec_top_defines.svh
// assertion macros shared by the codec modules
`ifndef SIX_BIT_TEXT_STREAM_CODEC_TOP_DEFINES_SVH
`define SIX_BIT_TEXT_STREAM_CODEC_TOP_DEFINES_SVH

// checked outside reset
`define STC_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STC_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/stc_pkg.sv
// shared types, constants and character helpers of the six-bit text codec
package stc_pkg;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_DIRECTION  = 1'b0,
    CFG_ENC_LENGTH = 1'b1
  } cfg_idx_t;

  localparam int unsigned CfgW   = 31;
  localparam int unsigned QDepth = 8;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned QIdxW  = $clog2(QDepth);

  localparam logic [7:0] CharOffset = 8'h3c;

  // header character counts while decoding
  localparam logic [2:0] HdrFirstA  = 3'd0;
  localparam logic [2:0] HdrSecondA = 3'd1;
  localparam logic [2:0] HdrLowDone = 3'd2;
  localparam logic [2:0] HdrFirstB  = 3'd3;
  localparam logic [2:0] HdrSecondB = 3'd4;
  localparam logic [2:0] HdrHighDone = 3'd5;
  localparam logic [2:0] HdrLen     = 3'd6;

  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhThird  = 2'd2;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } res_t;

  typedef res_t [2:0] res3_t;

  // up to six results of one item, r[0] leaves first
  typedef struct packed {
    logic [2:0]     n;
    res_t [5:0]     r;
  } batch_t;

  function automatic res3_t enc_pair(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic lastbit);
    res3_t t;
    t[0].value = {2'b00, b0[5:0]} + CharOffset;
    t[0].last  = 1'b0;
    t[1].value = {2'b00, b1[5:0]} + CharOffset;
    t[1].last  = 1'b0;
    t[2].value = {4'b0000, b1[7:6], b0[7:6]} + CharOffset;
    t[2].last  = lastbit;
    return t;
  endfunction

  // returns {b1, b0}
  function automatic logic [15:0] dec_triple(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    d0 = c0 - CharOffset;
    d1 = c1 - CharOffset;
    d2 = c2 - CharOffset;
    return {d1 | {d2[3:2], 6'b0}, d0 | {d2[1:0], 6'b0}};
  endfunction

endpackage

FILE: rtl/stc_core.sv
// codec state, configuration registers and result generation for one item
`include "six_bit_text_stream_codec_top_defines.svh"

module stc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  stc_pkg::cfg_idx_t         cfg_index,
  input  logic [stc_pkg::CfgW-1:0]  cfg_wdata,
  input  logic                      item_vld,
  input  stc_pkg::op_t              item_op,
  input  logic [7:0]                item_data,
  input  logic [stc_pkg::QCntW-1:0] space,
  output logic                      take,
  output stc_pkg::batch_t           batch
);
  import stc_pkg::*;

  dir_t        dir_r;
  logic [30:0] elen_r;
  logic [31:0] cnt_r, cnt_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [31:0] bef_r, bef_nxt;
  logic [7:0]  hf_r, hf_nxt;
  logic [7:0]  hs_r, hs_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [31:0] dlen_r, dlen_nxt;
  logic        fin_r, fin_nxt;

  logic [31:0] len32;
  logic [31:0] cnt_inc;
  logic [1:0]  ph_inc;
  logic [31:0] bef_inc;
  logic [31:0] rem;
  logic [31:0] dl_full;
  logic [15:0] pair_b;
  res3_t       t_lo, t_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      elen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION:  dir_r  <= dir_t'(cfg_wdata[0]);
        CFG_ENC_LENGTH: elen_r <= cfg_wdata;
        default:        dir_r  <= dir_r;
      endcase
    end
  end

  assign len32   = {1'b0, elen_r};
  assign cnt_inc = cnt_r + 32'd1;
  assign ph_inc  = (ph_r == PhThird) ? PhFirst : ph_r + 2'd1;
  assign bef_inc = (ph_r == PhThird) ? bef_r + 32'd2 : bef_r;
  assign rem     = dlen_r - bef_r;
  assign pair_b  = dec_triple(hf_r, hs_r, item_data);
  assign dl_full = dlen_r | {pair_b, 16'h0000};

  always_comb begin
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    bef_nxt  = bef_r;
    hf_nxt   = hf_r;
    hs_nxt   = hs_r;
    hdr_nxt  = hdr_r;
    dlen_nxt = dlen_r;
    fin_nxt  = fin_r;
    batch    = '0;
    t_lo     = '0;
    t_hi     = '0;
    if (item_op == OP_START) begin
      cnt_nxt  = '0;
      ph_nxt   = PhFirst;
      bef_nxt  = '0;
      hf_nxt   = '0;
      hs_nxt   = '0;
      hdr_nxt  = '0;
      dlen_nxt = '0;
      if (dir_r == DIR_ENCODE) begin
        fin_nxt = (elen_r == '0);
        t_lo = enc_pair(len32[7:0], len32[15:8], 1'b0);
        t_hi = enc_pair(len32[23:16], len32[31:24], fin_nxt);
        batch.n = 3'd6;
        batch.r = {t_hi, t_lo};
      end else begin
        fin_nxt = 1'b0;
      end
    end else if (!fin_r) begin
      if (dir_r == DIR_ENCODE) begin
        if (cnt_r >= len32) begin
          fin_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
          ph_nxt  = ph_inc;
          bef_nxt = bef_inc;
          if (cnt_inc[0]) begin
            hf_nxt = item_data;
            if (cnt_inc == len32) begin
              fin_nxt = 1'b1;
              t_lo = enc_pair(item_data, 8'h00, 1'b1);
              batch.n = 3'd3;
              batch.r[2:0] = t_lo;
            end
          end else begin
            fin_nxt = (cnt_inc == len32);
            t_lo = enc_pair(hf_r, item_data, fin_nxt);
            batch.n = 3'd3;
            batch.r[2:0] = t_lo;
          end
        end
      end else if (hdr_r < HdrLen) begin
        hdr_nxt = hdr_r + 3'd1;
        unique case (hdr_r)
          HdrFirstA, HdrFirstB:   hf_nxt = item_data;
          HdrSecondA, HdrSecondB: hs_nxt = item_data;
          HdrLowDone:             dlen_nxt = {16'h0000, pair_b};
          HdrHighDone: begin
            dlen_nxt = dl_full[31] ? 32'd0 : dl_full;
            if (dlen_nxt == '0) begin
              fin_nxt = 1'b1;
            end
          end
          default:                hdr_nxt = hdr_r;
        endcase
      end else if (bef_r >= dlen_r) begin
        fin_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        ph_nxt  = ph_inc;
        bef_nxt = bef_inc;
        unique case (ph_r)
          PhFirst:  hf_nxt = item_data;
          PhSecond: hs_nxt = item_data;
          PhThird: begin
            fin_nxt = (rem <= 32'd2);
            batch.r[0].value = pair_b[7:0];
            if (rem >= 32'd2) begin
              batch.n = 3'd2;
              batch.r[0].last = 1'b0;
              batch.r[1].value = pair_b[15:8];
              batch.r[1].last = fin_nxt;
            end else begin
              batch.n = 3'd1;
              batch.r[0].last = 1'b1;
            end
          end
          default:  ph_nxt = ph_r;
        endcase
      end
    end
  end

  assign take = item_vld && ({{(QCntW-3){1'b0}}, batch.n} <= space);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ph_r   <= PhFirst;
      bef_r  <= '0;
      hf_r   <= '0;
      hs_r   <= '0;
      hdr_r  <= '0;
      dlen_r <= '0;
      fin_r  <= 1'b1;
    end else if (take) begin
      cnt_r  <= cnt_nxt;
      ph_r   <= ph_nxt;
      bef_r  <= bef_nxt;
      hf_r   <= hf_nxt;
      hs_r   <= hs_nxt;
      hdr_r  <= hdr_nxt;
      dlen_r <= dlen_nxt;
      fin_r  <= fin_nxt;
    end
  end

  `STC_CHK(a_hdr_range, hdr_r <= HdrLen, "header count beyond six")
  `STC_CHK(a_phase_range, ph_r != 2'd3, "triple phase out of range")
  `STC_CHK(a_hdr_silent, (dir_r == DIR_DECODE && hdr_r < HdrLen) |-> batch.n == 3'd0,
           "decode header produced a result")
  `STC_CHK(a_idle_silent, (fin_r && item_op == OP_DATA) |-> batch.n == 3'd0,
           "result while idle")

endmodule

FILE: rtl/stc_outq.sv
// result queue that takes up to six results at once and drains one per transfer
`include "six_bit_text_stream_codec_top_defines.svh"

module stc_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  stc_pkg::batch_t           batch,
  output logic [stc_pkg::QCntW-1:0] space,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_value,
  output logic                      out_last
);
  import stc_pkg::*;

  res_t             q_r   [QDepth];
  res_t             q_nxt [QDepth];
  logic [QCntW-1:0] qn_r, qn_nxt;
  logic             pop;
  logic [QCntW-1:0] base;
  logic [QCntW-1:0] push_n;
  logic [QCntW-1:0] off;

  assign out_valid = (qn_r != '0);
  assign out_value = q_r[0].value;
  assign out_last  = q_r[0].last;
  assign pop       = out_valid && !out_stall;
  assign base      = qn_r - {{(QCntW-1){1'b0}}, pop};
  assign space     = QCntW'(QDepth) - base;
  assign push_n    = push ? {{(QCntW-3){1'b0}}, batch.n} : '0;
  assign qn_nxt    = base + push_n;

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      off = QCntW'(i) - base;
      if (pop && i < QDepth - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (QCntW'(i) >= base && off < push_n) begin
        q_nxt[i] = batch.r[off[2:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= '0;
    end else begin
      qn_r <= qn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  `STC_CHK_ALWAYS(a_q_bound, !rst_n || qn_r <= QCntW'(QDepth), "result queue overflow")
  `STC_CHK(a_q_fits, push |-> push_n <= space, "push beyond free space")
  `STC_CHK(a_q_count, (!push && !pop) |=> $stable(qn_r), "queue count moved while idle")

endmodule

FILE: rtl/six_bit_text_stream_codec_top.sv
// Six-bit text codec: packs byte pairs into three printable characters (offset 0x3c)
// behind a six-character length header, and unpacks such streams back to bytes.
// An accepted item is held in the input register until taken, is turned
// combinationally into up to six results, and those are written into an eight-entry
// result queue; a result is visible once it is registered in the queue. A new
// item enters every cycle as long as the queue has room for all its results, and
// results leave one per cycle while out_stall is low.
// Configuration (direction, encode length) must be written only while the block is
// idle; the block itself does not enforce this.
module six_bit_text_stream_codec_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  stc_pkg::cfg_idx_t         cfg_index,
  input  logic [stc_pkg::CfgW-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [7:0]                in_data_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_value,
  output logic                      out_last
);
  import stc_pkg::*;

  logic             in_vld_r, in_vld_nxt;
  op_t              in_op_r;
  logic [7:0]       in_data_r;
  logic             take;
  batch_t           batch;
  logic [QCntW-1:0] space;

  // input register
  assign in_stall   = in_vld_r && !take;
  assign in_vld_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= op_t'(in_operation);
      in_data_r <= in_data_value;
    end
  end

  stc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_vld  (in_vld_r),
    .item_op   (in_op_r),
    .item_data (in_data_r),
    .space     (space),
    .take      (take),
    .batch     (batch)
  );

  stc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .batch     (batch),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule
